### src/hrhp_pkg.sv
// Package for the HTTP request head parser: phase codes, status codes, token ROM helpers.
// No dependencies.
`default_nettype none
package hrhp_pkg;

   localparam int LengthBitsDefault = 32;

   typedef enum logic [3:0] {
      PH_METHOD   = 4'd0,
      PH_URL_LEAD = 4'd1,
      PH_PREFIX   = 4'd2,
      PH_HOST     = 4'd3,
      PH_URL      = 4'd4,
      PH_VER_LEAD = 4'd5,
      PH_VER      = 4'd6,
      PH_HNAME    = 4'd7,
      PH_CONN_LD  = 4'd8,
      PH_CONN_VAL = 4'd9,
      PH_LEN_LD   = 4'd10,
      PH_LEN_DIG  = 4'd11,
      PH_HSKIP    = 4'd12,
      PH_BODY     = 4'd13
   } phase_type;

   localparam logic [1:0] ST_BUSY     = 2'd0;
   localparam logic [1:0] ST_BAD      = 2'd1;
   localparam logic [1:0] ST_GET_DONE = 2'd2;
   localparam logic [1:0] ST_POST_DONE = 2'd3;

   typedef struct packed {
      logic [1:0] status;
      logic       url_valid;
      logic       body_valid;
      logic [7:0] data_byte;
      logic       is_post;
      logic       keep_alive;
      logic [31:0] body_length;
   } result_type;

   // Byte p of a token (upper case); returns 0 past the end.
   function automatic logic [7:0] tok_get(input logic [3:0] p);
      case (p)
         4'd0: tok_get = "G";
         4'd1: tok_get = "E";
         4'd2: tok_get = "T";
         default: tok_get = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] tok_post(input logic [3:0] p);
      case (p)
         4'd0: tok_post = "P";
         4'd1: tok_post = "O";
         4'd2: tok_post = "S";
         4'd3: tok_post = "T";
         default: tok_post = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] tok_ver(input logic [3:0] p);
      case (p)
         4'd0: tok_ver = "H";
         4'd1: tok_ver = "T";
         4'd2: tok_ver = "T";
         4'd3: tok_ver = "P";
         4'd4: tok_ver = "/";
         4'd5: tok_ver = "1";
         4'd6: tok_ver = ".";
         4'd7: tok_ver = "1";
         default: tok_ver = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] tok_pre(input logic [3:0] p);
      case (p)
         4'd0: tok_pre = "H";
         4'd1: tok_pre = "T";
         4'd2: tok_pre = "T";
         4'd3: tok_pre = "P";
         4'd4: tok_pre = ":";
         4'd5: tok_pre = "/";
         4'd6: tok_pre = "/";
         default: tok_pre = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] tok_conn(input logic [3:0] p);
      case (p)
         4'd0: tok_conn = "C";
         4'd1: tok_conn = "O";
         4'd2: tok_conn = "N";
         4'd3: tok_conn = "N";
         4'd4: tok_conn = "E";
         4'd5: tok_conn = "C";
         4'd6: tok_conn = "T";
         4'd7: tok_conn = "I";
         4'd8: tok_conn = "O";
         4'd9: tok_conn = "N";
         4'd10: tok_conn = ":";
         default: tok_conn = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] tok_clen(input logic [3:0] p);
      case (p)
         4'd0: tok_clen = "C";
         4'd1: tok_clen = "O";
         4'd2: tok_clen = "N";
         4'd3: tok_clen = "T";
         4'd4: tok_clen = "E";
         4'd5: tok_clen = "N";
         4'd6: tok_clen = "T";
         4'd7: tok_clen = "-";
         4'd8: tok_clen = "L";
         4'd9: tok_clen = "E";
         4'd10: tok_clen = "N";
         4'd11: tok_clen = "G";
         4'd12: tok_clen = "T";
         4'd13: tok_clen = "H";
         4'd14: tok_clen = ":";
         default: tok_clen = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] tok_keep(input logic [3:0] p);
      case (p)
         4'd0: tok_keep = "K";
         4'd1: tok_keep = "E";
         4'd2: tok_keep = "E";
         4'd3: tok_keep = "P";
         4'd4: tok_keep = "-";
         4'd5: tok_keep = "A";
         4'd6: tok_keep = "L";
         4'd7: tok_keep = "I";
         4'd8: tok_keep = "V";
         4'd9: tok_keep = "E";
         default: tok_keep = 8'h00;
      endcase
   endfunction

endpackage
`default_nettype wire

### src/hrhp_length_acc.sv
// Content-Length accumulator: value*10+digit with saturation at 2^LENGTH_BITS-1.
// Depends on hrhp_pkg.
`default_nettype none
module hrhp_length_acc import hrhp_pkg::*; #(
   parameter int LENGTH_BITS = LengthBitsDefault
) (
   input  wire logic [LENGTH_BITS-1:0] value,
   input  wire logic [3:0]             digit,
   output      logic [LENGTH_BITS-1:0] result
);
   logic [LENGTH_BITS+3:0] times_ten;
   logic [LENGTH_BITS+4:0] sum;
   assign times_ten = {1'b0, value, 3'b000} + {3'b000, value, 1'b0};
   assign sum = {1'b0, times_ten} + {{(LENGTH_BITS+1){1'b0}}, digit};
   assign result = (sum[LENGTH_BITS+4:LENGTH_BITS] != 5'd0) ? {LENGTH_BITS{1'b1}}
                                                            : sum[LENGTH_BITS-1:0];
endmodule
`default_nettype wire

### src/hrhp_parse.sv
// Parser state and next-state logic for one request byte per cycle while step is high.
// Depends on hrhp_pkg and hrhp_length_acc.
`default_nettype none
module hrhp_parse import hrhp_pkg::*; #(
   parameter int LENGTH_BITS = LengthBitsDefault
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] rx_byte,
   output      result_type result
);
   phase_type              phase_ff, phase_in;
   logic [3:0]             pos_ff, pos_in;
   logic [1:0]             flags_ff, flags_in;
   logic                   cr_ff, cr_in, empty_ff, empty_in;
   logic                   post_ff, post_in, keep_ff, keep_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in, left_ff, left_in, len_next, left_dec;
   logic [7:0]             u;
   logic                   blank, digit, bad, done, uv, bv;
   logic [3:0]             pos_inc, pos_sat;
   logic [1:0]             fl;

   hrhp_length_acc #(.LENGTH_BITS(LENGTH_BITS)) u_acc (
      .value(len_ff), .digit(rx_byte[3:0]), .result(len_next));

   assign u = (rx_byte >= "a" && rx_byte <= "z") ? rx_byte - 8'd32 : rx_byte;
   assign blank = rx_byte == " " || rx_byte == 8'h09;
   assign digit = rx_byte >= "0" && rx_byte <= "9";
   assign pos_inc = pos_ff + 4'd1;
   assign pos_sat = (pos_ff == 4'd15) ? pos_ff : pos_inc;
   assign left_dec = (left_ff != '0) ? left_ff - LENGTH_BITS'(1) : left_ff;

   always_comb begin
      phase_in = phase_ff; pos_in = pos_ff; flags_in = flags_ff; cr_in = cr_ff;
      empty_in = empty_ff; post_in = post_ff; keep_in = keep_ff;
      len_in = len_ff; left_in = left_ff;
      bad = 1'b0; done = 1'b0; uv = 1'b0; bv = 1'b0; fl = flags_ff;
      if (phase_ff == PH_BODY) begin
         bv = 1'b1;
         left_in = left_dec;
         if (left_dec == '0) done = 1'b1;
      end else if (cr_ff) begin
         cr_in = 1'b0;
         if (rx_byte != 8'h0A) begin
            bad = 1'b1;
         end else begin
            case (phase_ff)
               PH_VER: begin
                  if (pos_ff == 4'd8) begin
                     phase_in = PH_HNAME; pos_in = '0; flags_in = 2'b11; empty_in = 1'b1;
                  end else bad = 1'b1;
               end
               PH_HNAME: begin
                  if (!empty_ff) begin
                     pos_in = '0; flags_in = 2'b11; empty_in = 1'b1;
                  end else if (len_ff != '0) begin
                     phase_in = PH_BODY; left_in = len_ff;
                  end else done = 1'b1;
               end
               PH_CONN_VAL, PH_CONN_LD, PH_LEN_LD, PH_LEN_DIG, PH_HSKIP: begin
                  if (phase_ff == PH_CONN_VAL && pos_ff == 4'd10) keep_in = 1'b1;
                  phase_in = PH_HNAME; pos_in = '0; flags_in = 2'b11; empty_in = 1'b1;
               end
               default: bad = 1'b1;
            endcase
         end
      end else if (rx_byte == 8'h0D) begin
         cr_in = 1'b1;
      end else if (rx_byte == 8'h0A) begin
         bad = 1'b1;
      end else begin
         case (phase_ff)
            PH_METHOD: begin
               if (blank) begin
                  if (flags_ff[0] && pos_ff == 4'd3) begin
                     post_in = 1'b0; phase_in = PH_URL_LEAD;
                  end else if (flags_ff[1] && pos_ff == 4'd4) begin
                     post_in = 1'b1; phase_in = PH_URL_LEAD;
                  end else bad = 1'b1;
               end else begin
                  if (!(pos_ff < 4'd3 && tok_get(pos_ff) == u)) fl[0] = 1'b0;
                  if (!(pos_ff < 4'd4 && tok_post(pos_ff) == u)) fl[1] = 1'b0;
                  flags_in = fl; pos_in = pos_sat;
                  if (fl == 2'b00) bad = 1'b1;
               end
            end
            PH_URL_LEAD: begin
               if (!blank) begin
                  if (rx_byte == "/") begin
                     uv = 1'b1; phase_in = PH_URL;
                  end else if (u == "H") begin
                     pos_in = 4'd1; phase_in = PH_PREFIX;
                  end else bad = 1'b1;
               end
            end
            PH_PREFIX: begin
               if (pos_ff < 4'd7 && tok_pre(pos_ff) == u) begin
                  pos_in = pos_inc;
                  if (pos_inc == 4'd7) phase_in = PH_HOST;
               end else bad = 1'b1;
            end
            PH_HOST: begin
               if (blank) bad = 1'b1;
               else if (rx_byte == "/") begin
                  uv = 1'b1; phase_in = PH_URL;
               end
            end
            PH_URL: begin
               if (blank) phase_in = PH_VER_LEAD;
               else uv = 1'b1;
            end
            PH_VER_LEAD: begin
               if (!blank) begin
                  if (u == "H") begin
                     pos_in = 4'd1; phase_in = PH_VER;
                  end else bad = 1'b1;
               end
            end
            PH_VER: begin
               if (pos_ff < 4'd8 && tok_ver(pos_ff) == u) pos_in = pos_inc;
               else bad = 1'b1;
            end
            PH_HNAME: begin
               empty_in = 1'b0;
               if (!(pos_ff < 4'd11 && tok_conn(pos_ff) == u)) fl[0] = 1'b0;
               if (!(pos_ff < 4'd15 && tok_clen(pos_ff) == u)) fl[1] = 1'b0;
               flags_in = fl; pos_in = pos_sat;
               if (fl[0] && pos_sat == 4'd11) phase_in = PH_CONN_LD;
               else if (fl[1] && pos_sat == 4'd15) begin
                  phase_in = PH_LEN_LD; len_in = '0;
               end else if (fl == 2'b00) phase_in = PH_HSKIP;
            end
            PH_CONN_LD: begin
               if (!blank) begin
                  if (u == "K") begin
                     pos_in = 4'd1; phase_in = PH_CONN_VAL;
                  end else phase_in = PH_HSKIP;
               end
            end
            PH_CONN_VAL: begin
               if (pos_ff < 4'd10 && tok_keep(pos_ff) == u) pos_in = pos_inc;
               else phase_in = PH_HSKIP;
            end
            PH_LEN_LD: begin
               if (!(blank || rx_byte == 8'h0B || rx_byte == 8'h0C)) begin
                  if (digit) begin
                     len_in = LENGTH_BITS'(rx_byte[3:0]); phase_in = PH_LEN_DIG;
                  end else phase_in = PH_HSKIP;
               end
            end
            PH_LEN_DIG: begin
               if (digit) len_in = len_next;
               else phase_in = PH_HSKIP;
            end
            PH_HSKIP: ;
            default: bad = 1'b1;
         endcase
      end
   end

   // flags and length are reported as updated by this byte
   always_comb begin
      result.status = bad ? ST_BAD : (done ? (post_ff ? ST_POST_DONE : ST_GET_DONE) : ST_BUSY);
      result.url_valid = uv && !bad;
      result.body_valid = bv && !bad;
      result.data_byte = ((uv || bv) && !bad) ? rx_byte : 8'h00;
      result.is_post = post_in;
      result.keep_alive = keep_in;
      if (LENGTH_BITS > 32) begin
         result.body_length = (len_in > LENGTH_BITS'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                     : 32'(len_in);
      end else begin
         result.body_length = 32'(len_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && (bad || done))) begin
         phase_ff <= PH_METHOD; pos_ff <= '0; flags_ff <= 2'b11; cr_ff <= 1'b0;
         empty_ff <= 1'b1; post_ff <= 1'b0; keep_ff <= 1'b0;
         len_ff <= '0; left_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in; pos_ff <= pos_in; flags_ff <= flags_in; cr_ff <= cr_in;
         empty_ff <= empty_in; post_ff <= post_in; keep_ff <= keep_in;
         len_ff <= len_in; left_ff <= left_in;
      end
   end
endmodule
`default_nettype wire

### src/http_request_head_parser_core.sv
// HTTP request head parser top level: input byte register, parser, result register.
// Depends on hrhp_pkg and hrhp_parse.
//
// Usage: request bytes enter on the req_ stream, one byte per transaction.
// Every accepted byte yields exactly one result transaction on rsp_.
// rsp_tdata carries status, url_valid, body_valid, data_byte, is_post,
// keep_alive and body_length. Status is 0 while a request is in progress,
// 1 on a bad request, 2 on a completed GET and 3 on a completed POST;
// after 1, 2 or 3 the parser is back at the start of a new request.
// An accepted byte is held in the input register, which feeds the parser;
// the result register loads when the parser steps. Throughput: one byte
// per cycle while the receiver does not stall; the parser state registers
// are updated once per byte.
// Reset (synchronous, active high) empties both registers and returns the
// parser to the method phase. When the receiver stalls, the result holds
// and the input register fills, after which req_tready drops.
`default_nettype none
module http_request_head_parser_core import hrhp_pkg::*; #(
   parameter int LENGTH_BITS = LengthBitsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [47:0] rsp_tdata    // [1:0] status, [2] url_valid, [3] body_valid,
                                         // [11:4] data_byte, [12] is_post,
                                         // [13] keep_alive, [45:14] body_length, rest 0
);
   logic       in_vld_ff;
   logic [7:0] in_byte_ff;
   logic       out_vld_ff;
   logic [47:0] out_data_ff;
   logic       step;
   result_type res;

   assign step = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || step;

   hrhp_parse #(.LENGTH_BITS(LENGTH_BITS)) u_parse (
      .clock(clock), .reset(reset), .step(step), .rx_byte(in_byte_ff), .result(res));

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (req_tready) in_vld_ff <= req_tvalid;
         if (step) out_vld_ff <= 1'b1;
         else if (rsp_tready) out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) in_byte_ff <= req_tdata;
      if (step) out_data_ff <= {2'b00, res.body_length, res.keep_alive, res.is_post,
                                res.data_byte, res.body_valid, res.url_valid, res.status};
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata = out_data_ff;
endmodule
`default_nettype wire

### src/hrhp_checker.sv
// Port-level checker for the HTTP request head parser core, bound to the top level.
// Depends on http_request_head_parser_core.
`default_nettype none
module hrhp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata
);
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[2] && rsp_tdata[3]))
      else $error("url and body flagged together");
   a_bad_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == 2'd1 |-> rsp_tdata[11:2] == 10'd0)
      else $error("bad result carries data");
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[47:46] == 2'b00)
      else $error("padding not zero");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("not empty after reset");
endmodule

bind http_request_head_parser_core hrhp_checker u_hrhp_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));
`default_nettype wire
